// File: src/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and tables for the sorted bucket codec
// Request and response structs, pipeline stage payload, and the rank
// tables used by both the encoder sum and the decoder digit search.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // C(19,4): first rank with no valid nibble tuple
  localparam logic [11:0] RANK_LIMIT = 12'd3876;

  typedef struct packed {
    logic        operation;
    logic [4:0]  value_0;
    logic [4:0]  value_1;
    logic [4:0]  value_2;
    logic [4:0]  value_3;
    logic [15:0] code_in;
  } req_t;

  typedef struct packed {
    logic [15:0] code_out;
    logic [4:0]  out_0;
    logic [4:0]  out_1;
    logic [4:0]  out_2;
    logic [4:0]  out_3;
    logic        bad_code;
  } res_t;

  typedef logic [3:0][4:0] quad_t;

  typedef struct packed {
    logic        op;
    logic        bad;
    logic [11:0] rank;
    logic [3:0]  cap;
    logic [3:0]  low;
    quad_t       v;
  } pipe_t;

  // Row 0: C(x+3,4), row 1: C(x+2,3), row 2: C(x+1,2), row 3: x
  localparam logic [11:0] TERM_TAB [4][16] = '{
    '{12'd0, 12'd1, 12'd5, 12'd15, 12'd35, 12'd70, 12'd126, 12'd210,
      12'd330, 12'd495, 12'd715, 12'd1001, 12'd1365, 12'd1820, 12'd2380, 12'd3060},
    '{12'd0, 12'd1, 12'd4, 12'd10, 12'd20, 12'd35, 12'd56, 12'd84,
      12'd120, 12'd165, 12'd220, 12'd286, 12'd364, 12'd455, 12'd560, 12'd680},
    '{12'd0, 12'd1, 12'd3, 12'd6, 12'd10, 12'd15, 12'd21, 12'd28,
      12'd36, 12'd45, 12'd55, 12'd66, 12'd78, 12'd91, 12'd105, 12'd120},
    '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7,
      12'd8, 12'd9, 12'd10, 12'd11, 12'd12, 12'd13, 12'd14, 12'd15}
  };

endpackage

// File: src/sbc_sort4.sv
// ----------------------------------------------------------------------------
// sbc_sort4: four-input descending sort network
// Five compare-exchange cells in three levels; position 0 gets the largest.
// ----------------------------------------------------------------------------
module sbc_sort4 (
  input  sbc_pkg::quad_t vals,
  output sbc_pkg::quad_t sorted
);
  import sbc_pkg::*;

  quad_t l1;
  quad_t l2;

  always_comb begin
    l1 = vals;
    if (vals[0] < vals[1]) begin
      l1[0] = vals[1];
      l1[1] = vals[0];
    end
    if (vals[2] < vals[3]) begin
      l1[2] = vals[3];
      l1[3] = vals[2];
    end
    l2 = l1;
    if (l1[0] < l1[2]) begin
      l2[0] = l1[2];
      l2[2] = l1[0];
    end
    if (l1[1] < l1[3]) begin
      l2[1] = l1[3];
      l2[3] = l1[1];
    end
    sorted = l2;
    if (l2[1] < l2[2]) begin
      sorted[1] = l2[2];
      sorted[2] = l2[1];
    end
  end

endmodule

// File: src/sbc_dec_step.sv
// ----------------------------------------------------------------------------
// sbc_dec_step: one decode digit
// Finds the largest nibble x <= cap whose table term fits in the remaining
// rank, and returns x with the rank left after taking that term off.
// ----------------------------------------------------------------------------
module sbc_dec_step (
  input  logic [1:0]  which,
  input  logic [11:0] rank,
  input  logic [3:0]  cap,
  output logic [3:0]  digit,
  output logic [11:0] rem
);
  import sbc_pkg::*;

  always_comb begin
    digit = '0;
    for (int k = 1; k < 16; k++) begin
      if (4'(k) <= cap && TERM_TAB[which][k] <= rank) begin
        digit = 4'(k);
      end
    end
    rem = rank - TERM_TAB[which][digit];
  end

endmodule

// File: src/sorted_bucket_codec_top.sv
// ----------------------------------------------------------------------------
// sorted_bucket_codec_top: semi-sorted bucket encoder / decoder
// Four-stage pipeline; encode sorts then ranks, decode peels one digit a stage.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high and returns the responses
// in order; the pipeline has four stages, one for each decode digit search
// (encode sorts in the first stage and sums the rank in the second).
// Each stage advances on its own, so a stalled response only holds back the
// stages behind it and empty slots are filled while the output waits.
// Decoding a rank of 3876 or more sets bad_code and zeroes the values.
module sorted_bucket_codec_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sbc_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output sbc_pkg::res_t res_data
);
  import sbc_pkg::*;

  logic  stg_valid [4];
  pipe_t stg       [4];
  pipe_t stg_next  [4];
  logic [4:0] rdy;

  quad_t in_vals;
  quad_t in_sorted;

  logic [3:0][3:0]  dig;
  logic [3:0][11:0] rem;
  logic [3:0][11:0] dec_rank;
  logic [3:0][3:0]  dec_cap;

  assign in_vals = {req_data.value_3, req_data.value_2, req_data.value_1, req_data.value_0};

  sbc_sort4 u_sort (
    .vals   (in_vals),
    .sorted (in_sorted)
  );

  assign dec_rank[0] = req_data.code_in[15:4];
  assign dec_cap[0]  = 4'hf;
  for (genvar g = 1; g < 4; g++) begin : g_dsrc
    assign dec_rank[g] = stg[g-1].rank;
    assign dec_cap[g]  = stg[g-1].cap;
  end

  for (genvar g = 0; g < 4; g++) begin : g_dstep
    sbc_dec_step u_step (
      .which (2'(g)),
      .rank  (dec_rank[g]),
      .cap   (dec_cap[g]),
      .digit (dig[g]),
      .rem   (rem[g])
    );
  end

  // stage next values
  always_comb begin
    stg_next[0].op   = req_data.operation;
    stg_next[0].bad  = 1'b0;
    stg_next[0].rank = '0;
    stg_next[0].cap  = '0;
    stg_next[0].low  = '0;
    stg_next[0].v    = in_sorted;
    if (req_data.operation == OP_DECODE) begin
      stg_next[0].bad  = (req_data.code_in[15:4] >= RANK_LIMIT);
      stg_next[0].rank = rem[0];
      stg_next[0].cap  = dig[0];
      stg_next[0].low  = req_data.code_in[3:0];
      stg_next[0].v    = '0;
      stg_next[0].v[0] = {dig[0], req_data.code_in[0]};
    end

    stg_next[1] = stg[0];
    if (stg[0].op == OP_ENCODE) begin
      stg_next[1].rank = TERM_TAB[0][stg[0].v[0][4:1]] + TERM_TAB[1][stg[0].v[1][4:1]]
                       + TERM_TAB[2][stg[0].v[2][4:1]] + TERM_TAB[3][stg[0].v[3][4:1]];
      stg_next[1].low  = {stg[0].v[3][0], stg[0].v[2][0], stg[0].v[1][0], stg[0].v[0][0]};
    end else begin
      stg_next[1].rank = rem[1];
      stg_next[1].cap  = dig[1];
      stg_next[1].v[1] = {dig[1], stg[0].low[1]};
    end

    for (int k = 2; k < 4; k++) begin
      stg_next[k] = stg[k-1];
      if (stg[k-1].op == OP_DECODE) begin
        stg_next[k].rank = rem[k];
        stg_next[k].cap  = dig[k];
        stg_next[k].v[k] = {dig[k], stg[k-1].low[k]};
      end
    end
  end

  // per-stage ready: a stage loads when empty or when it drains this cycle
  always_comb begin
    rdy[4] = res_ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !stg_valid[k] || rdy[k+1];
    end
  end

  assign req_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        stg_valid[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        stg_valid[0] <= req_valid;
      end
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) begin
          stg_valid[k] <= stg_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (rdy[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  logic dec_ok;
  assign dec_ok = (stg[3].op == OP_DECODE) && !stg[3].bad;

  assign res_valid         = stg_valid[3];
  assign res_data.code_out = (stg[3].op == OP_ENCODE) ? {stg[3].rank, stg[3].low} : 16'h0;
  assign res_data.out_0    = dec_ok ? stg[3].v[0] : 5'h0;
  assign res_data.out_1    = dec_ok ? stg[3].v[1] : 5'h0;
  assign res_data.out_2    = dec_ok ? stg[3].v[2] : 5'h0;
  assign res_data.out_3    = dec_ok ? stg[3].v[3] : 5'h0;
  assign res_data.bad_code = (stg[3].op == OP_DECODE) && stg[3].bad;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.bad_code |->
      res_data.code_out == 16'h0 && res_data.out_0 == 5'h0 && res_data.out_3 == 5'h0)
    else $error("bad code response carries data");

  // only the nibbles are ordered; the low bits come straight from the code word
  a_dec_sorted: assert property (@(posedge clk) disable iff (rst)
    res_valid && dec_ok |->
      res_data.out_0[4:1] >= res_data.out_1[4:1] && res_data.out_1[4:1] >= res_data.out_2[4:1]
      && res_data.out_2[4:1] >= res_data.out_3[4:1])
    else $error("decoded values not in descending order");

  a_enc_rank: assert property (@(posedge clk) disable iff (rst)
    stg_valid[1] && stg[1].op == OP_ENCODE |-> stg[1].rank < RANK_LIMIT)
    else $error("encode rank out of range");

endmodule
